>>> rtl/core/bmc_pkg.sv
// Shared types and constants for the button mode controller.
// No dependencies; compile first.
package bmc_pkg;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_HOME     = 2'd1,
    CMD_SCENARIO = 2'd2,
    CMD_DISABLE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_HOMING   = 2'd0,
    MODE_READY    = 2'd1,
    MODE_SCENARIO = 2'd2,
    MODE_SERIAL   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SCENARIO_COUNT = 2'd0,
    CFG_DEBOUNCE       = 2'd1,
    CFG_LONG_PRESS     = 2'd2,
    CFG_TIMEOUT        = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TickW    = 16;
  localparam int unsigned ScenW    = 8;

  localparam logic [ScenW-1:0] ScenCountRst = 8'd3;
  localparam logic [7:0]       DebounceRst  = 8'd5;
  localparam logic [TickW-1:0] LongPressRst = 16'd300;
  localparam logic [TickW-1:0] TimeoutRst   = 16'd30000;
  localparam logic [TickW-1:0] TickMax      = 16'hFFFF;

  // Press events for one tick, from the press classifier to the mode logic.
  typedef struct packed {
    logic short_press;
    logic long_press;
  } bmc_press_t;

endpackage

>>> rtl/core/bmc_if.sv
// Valid/ready channel interfaces: poll tick input, result output, config writes.
// Depends on bmc_pkg.
interface bmc_in_if;
  logic valid;
  logic ready;
  logic button_pressed;
  logic homing_busy;

  modport source (output valid, output button_pressed, output homing_busy, input ready);
  modport sink   (input valid, input button_pressed, input homing_busy, output ready);
endinterface

interface bmc_out_if;
  logic                   valid;
  logic                   ready;
  bmc_pkg::cmd_e          command;
  logic [bmc_pkg::ScenW-1:0] scenario_id;
  bmc_pkg::mode_e         mode;

  modport source (output valid, output command, output scenario_id, output mode, input ready);
  modport sink   (input valid, input command, input scenario_id, input mode, output ready);
endinterface

interface bmc_cfg_if;
  logic                         valid;
  logic                         ready;
  bmc_pkg::cfg_idx_e            index;
  logic [bmc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/bmc_press.sv
// Press classifier: times button presses and flags short and long presses.
// Depends on bmc_pkg.
module bmc_press (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      pressed_i,
  input  logic [7:0]                debounce_i,
  input  logic [bmc_pkg::TickW-1:0] long_press_i,
  output bmc_pkg::bmc_press_t       event_o
);
  import bmc_pkg::*;

  logic             was_pressed_q, was_pressed_d;
  logic             long_fired_q, long_fired_d;
  logic [TickW-1:0] press_ticks_q, press_ticks_d;
  logic [TickW-1:0] ticks_adv;

  always_comb begin
    ticks_adv = press_ticks_q;
    if (was_pressed_q && press_ticks_q != TickMax) begin
      ticks_adv = press_ticks_q + 1'b1;
    end
    was_pressed_d        = was_pressed_q;
    long_fired_d         = long_fired_q;
    press_ticks_d        = ticks_adv;
    event_o.short_press  = 1'b0;
    event_o.long_press   = 1'b0;
    if (pressed_i && !was_pressed_q) begin
      // restart the timer on the press edge
      press_ticks_d = '0;
      was_pressed_d = 1'b1;
      long_fired_d  = 1'b0;
    end else if (pressed_i) begin
      if (!long_fired_q && ticks_adv >= long_press_i) begin
        long_fired_d       = 1'b1;
        event_o.long_press = 1'b1;
      end
    end else if (was_pressed_q) begin
      was_pressed_d = 1'b0;
      if (!long_fired_q && ticks_adv >= {8'd0, debounce_i}) begin
        event_o.short_press = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q <= 1'b0;
      long_fired_q  <= 1'b0;
      press_ticks_q <= '0;
    end else if (en_i) begin
      was_pressed_q <= was_pressed_d;
      long_fired_q  <= long_fired_d;
      press_ticks_q <= press_ticks_d;
    end
  end

endmodule

>>> rtl/core/button_mode_controller.sv
// Button mode controller top level: input register, mode logic, result register.
// Depends on bmc_pkg, bmc_if.sv and bmc_press.
//
// Usage
//   in_i  : one item per poll tick, carrying button_pressed (1 = held) and
//           homing_busy. Items are accepted when valid and ready are high.
//   out_o : one result item per input item: command (none, start homing,
//           start scenario, disable motor), scenario_id and mode after the tick.
//   cfg_i : register writes (scenario count, debounce ticks, long press ticks,
//           timeout ticks); always ready, to be used only while the block is idle.
// Path: an accepted item is held in the input register, and its result is
//   loaded from there into the output register once that register is free
//   or being drained; the result item is then offered on out_o.
// Throughput: one item per cycle unless out_o stalls; the input and result
//   registers form a two-stage pipeline; a new item is taken as a result waits.
// Stall: when out_o.ready is low the result holds, the input register fills
//   and then in_i.ready drops until the result is taken.
// Reset: mode homing, scenario 0, press and scenario timers cleared, config
//   registers at 3, 5, 300 and 30000. No clearing pass; ready after reset.
module button_mode_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmc_in_if.sink     in_i,
  bmc_out_if.source  out_o,
  bmc_cfg_if.sink    cfg_i
);
  import bmc_pkg::*;

  // Configuration registers
  logic [ScenW-1:0] scen_count_q;
  logic [7:0]       debounce_q;
  logic [TickW-1:0] long_press_q;
  logic [TickW-1:0] timeout_q;

  // Input register
  logic in_vld_q;
  logic pressed_q;
  logic busy_q;

  // Mode state
  mode_e            mode_q, mode_d;
  logic [ScenW-1:0] scen_q, scen_d;
  logic             basal_q, basal_d;
  logic [TickW-1:0] scen_ticks_q, scen_ticks_d;
  cmd_e             cmd_d;

  // Result register
  logic             out_vld_q;
  cmd_e             out_cmd_q;
  logic [ScenW-1:0] out_scen_q;
  mode_e            out_mode_q;

  logic       adv;
  logic       work;
  logic       in_rdy;
  bmc_press_t press;
  logic [ScenW-1:0] scen_next;

  // Advance the pipeline when the result register is free or being drained.
  assign adv    = !out_vld_q || out_o.ready;
  assign work   = in_vld_q && adv;
  assign in_rdy = !in_vld_q || adv;
  assign in_i.ready  = in_rdy;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scen_count_q <= ScenCountRst;
      debounce_q   <= DebounceRst;
      long_press_q <= LongPressRst;
      timeout_q    <= TimeoutRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SCENARIO_COUNT: scen_count_q <= cfg_i.data[ScenW-1:0];
        CFG_DEBOUNCE:       debounce_q   <= cfg_i.data[7:0];
        CFG_LONG_PRESS:     long_press_q <= cfg_i.data;
        CFG_TIMEOUT:        timeout_q    <= cfg_i.data;
        default:            ;
      endcase
    end
  end

  // Capture the tick; drop the valid once it moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      pressed_q <= in_i.button_pressed;
      busy_q    <= in_i.homing_busy;
    end
  end

  bmc_press u_press (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (work),
    .pressed_i    (pressed_q),
    .debounce_i   (debounce_q),
    .long_press_i (long_press_q),
    .event_o      (press)
  );

  // Next scenario, wrapping to one past the count or past 255.
  always_comb begin
    scen_next = scen_q + 1'b1;
    if (scen_next == '0 || scen_next > scen_count_q) begin
      scen_next = ScenW'(1);
    end
  end

  always_comb begin
    mode_d       = mode_q;
    scen_d       = scen_q;
    basal_d      = basal_q;
    cmd_d        = CMD_NONE;
    scen_ticks_d = scen_ticks_q;
    if (mode_q == MODE_SCENARIO && scen_ticks_q != TickMax) begin
      scen_ticks_d = scen_ticks_q + 1'b1;
    end

    // Button events act on the mode held before this tick.
    if (press.short_press) begin
      case (mode_q)
        MODE_READY: begin
          basal_d = 1'b1;
          scen_d  = '0;
          mode_d  = MODE_HOMING;
          cmd_d   = CMD_HOME;
        end
        MODE_SCENARIO: begin
          scen_d       = scen_next;
          scen_ticks_d = '0;
          cmd_d        = CMD_SCENARIO;
        end
        default: ;
      endcase
    end else if (press.long_press) begin
      case (mode_q)
        MODE_READY: mode_d = MODE_SERIAL;
        MODE_SCENARIO, MODE_SERIAL: begin
          basal_d = 1'b0;
          scen_d  = '0;
          mode_d  = MODE_HOMING;
          cmd_d   = CMD_HOME;
        end
        default: ;
      endcase
    end

    // Homing finished: skip in a tick that has just commanded homing.
    if (mode_d == MODE_HOMING && cmd_d != CMD_HOME && !busy_q) begin
      if (basal_q) begin
        basal_d      = 1'b0;
        scen_d       = ScenW'(1);
        mode_d       = MODE_SCENARIO;
        scen_ticks_d = '0;
        cmd_d        = CMD_SCENARIO;
      end else begin
        scen_d = '0;
        mode_d = MODE_READY;
        cmd_d  = CMD_DISABLE;
      end
    end

    // Fall back to scenario one once a demanding scenario times out.
    if (mode_d == MODE_SCENARIO && scen_d > ScenW'(1) && scen_ticks_d >= timeout_q) begin
      scen_d       = ScenW'(1);
      scen_ticks_d = '0;
      cmd_d        = CMD_SCENARIO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_HOMING;
      scen_q       <= '0;
      basal_q      <= 1'b0;
      scen_ticks_q <= '0;
    end else if (work) begin
      mode_q       <= mode_d;
      scen_q       <= scen_d;
      basal_q      <= basal_d;
      scen_ticks_q <= scen_ticks_d;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      out_cmd_q  <= cmd_d;
      out_scen_q <= scen_d;
      out_mode_q <= mode_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.command     = out_cmd_q;
  assign out_o.scenario_id = out_scen_q;
  assign out_o.mode        = out_mode_q;

`ifndef SYNTHESIS
  a_scen_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_cmd_q == CMD_SCENARIO |-> out_mode_q == MODE_SCENARIO && out_scen_q != '0)
    else $error("scenario start without scenario mode");

  a_idle_scen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_mode_q != MODE_SCENARIO |-> out_scen_q == '0)
    else $error("nonzero scenario outside scenario mode");

  a_home_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_cmd_q == CMD_HOME |-> out_mode_q == MODE_HOMING)
    else $error("homing command without homing mode");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_i.ready)
    else $error("input stalled with empty result register");
`endif

endmodule
